>>> rtl/ax25_hdlc_pkg.sv
// ----------------------------------------------------------------------------
// AX.25 HDLC encoder package
// Shared constants, register indexes, state codes and the bit-reverse helper of the encoder.
// ----------------------------------------------------------------------------
package ax25_hdlc_pkg;

	localparam int END_FLAGS   = 5;
	localparam int MAX_RESULTS = 32;
	localparam int RES_AW      = $clog2(MAX_RESULTS);
	localparam int RES_CW      = $clog2(MAX_RESULTS + 1);
	localparam int FLAG_CW     = $clog2(END_FLAGS + 1);

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 48;
	localparam int CALL_W     = 48;
	localparam int SSID_W     = 4;
	localparam int LIMIT_W    = 12;

	localparam logic [CFG_IDX_W-1:0] CFG_DEST_CALL = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEST_SSID = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SRC_CALL  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SRC_SSID  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CONTROL   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_PID       = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT     = 3'd6;

	localparam logic [7:0]         CONTROL_RESET = 8'h03;
	localparam logic [7:0]         PID_RESET     = 8'hF0;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET   = 12'd330;

	localparam logic [15:0] CRC_INIT  = 16'hFFFF;
	localparam logic [15:0] CRC_POLY  = 16'h1021;
	localparam logic [7:0]  FLAG_BYTE = 8'h7E;
	localparam logic [7:0]  PAD_CHAR  = 8'h20;
	localparam logic [2:0]  STUFF_RUN = 3'd5;
	localparam logic [3:0]  BYTE_BITS = 4'd8;
	localparam logic [2:0]  BIT_TOP   = 3'd7;

	// Upper three bits of the SSID bytes: command bit and reserved bits.
	localparam logic [2:0] DEST_SSID_TOP = 3'b111;
	localparam logic [2:0] SRC_SSID_TOP  = 3'b011;

	localparam logic [3:0] HDR_DEST_SSID = 4'd6;
	localparam logic [3:0] HDR_SRC_SSID  = 4'd13;
	localparam logic [3:0] HDR_CONTROL   = 4'd14;
	localparam logic [3:0] HDR_PID       = 4'd15;

	localparam int ST_W = 4;
	localparam logic [ST_W-1:0] ST_IDLE  = 4'd0;
	localparam logic [ST_W-1:0] ST_HDR   = 4'd1;
	localparam logic [ST_W-1:0] ST_DATA  = 4'd2;
	localparam logic [ST_W-1:0] ST_CRCH  = 4'd3;
	localparam logic [ST_W-1:0] ST_CRCL  = 4'd4;
	localparam logic [ST_W-1:0] ST_FLAG  = 4'd5;
	localparam logic [ST_W-1:0] ST_PAD   = 4'd6;
	localparam logic [ST_W-1:0] ST_FIN   = 4'd7;
	localparam logic [ST_W-1:0] ST_DRAIN = 4'd8;

	function automatic logic [7:0] reverse8(input logic [7:0] v);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) begin
			r[7-i] = v[i];
		end
		return r;
	endfunction

endpackage

>>> rtl/ax25_hdlc_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port and single read port with registered read data.
// ----------------------------------------------------------------------------
module ax25_hdlc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> rtl/ax25_hdlc_frame_encoder_unit.sv
// ----------------------------------------------------------------------------
// AX.25 HDLC frame encoder
// Builds header, bit-stuffed payload, CRC and closing flags, packed into bytes.
// ----------------------------------------------------------------------------
//  channel   dir   handshake              payload
//  input     in    in_valid / in_ready    data_byte, byte_valid, frame_end
//  output    out   out_valid / out_ready  out_byte, out_last, truncated
//  config    in    cfg_wr_en              cfg_index, cfg_wr_data
//
// Every encoded byte goes through a limit check, then its data bits and any
// stuffed zeros one at a time, then a closing step. Opening a frame adds the
// 16 header bytes; closing adds two CRC bytes, five flags sent bit by bit, a
// pad step and a finish step. The results of an item are buffered and then
// sent byte by byte, since truncated is known only at the end of the item.
// Reset puts the block idle with no frame open; no item is taken until the
// buffered results of the previous item have all been moved to the output
// register.
module ax25_hdlc_frame_encoder_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [7:0]                           data_byte,
	input  logic                                 byte_valid,
	input  logic                                 frame_end,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [7:0]                           out_byte,
	output logic                                 out_last,
	output logic                                 truncated,
	input  logic                                 cfg_wr_en,
	input  logic [ax25_hdlc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ax25_hdlc_pkg::CFG_DATA_W-1:0] cfg_wr_data
);

	logic [ax25_hdlc_pkg::CALL_W-1:0]  dest_call_q, src_call_q;
	logic [ax25_hdlc_pkg::SSID_W-1:0]  dest_ssid_q, src_ssid_q;
	logic [7:0]                        control_q, pid_q;
	logic [ax25_hdlc_pkg::LIMIT_W-1:0] limit_q;

	logic [ax25_hdlc_pkg::ST_W-1:0]    state_q;
	logic                              item_valid_q, item_fend_q;
	logic [7:0]                        data_q;
	logic                              in_frame_q;
	logic [15:0]                       crc_q;
	logic [2:0]                        ones_q;
	logic [2:0]                        bitpos_q;
	logic [7:0]                        partial_q;
	logic [ax25_hdlc_pkg::LIMIT_W-1:0] out_cnt_q;
	logic                              dropped_q;
	logic [3:0]                        hdr_idx_q;
	logic [ax25_hdlc_pkg::CALL_W-1:0]  call_sh_q;
	logic                              pad_q;
	logic                              byte_act_q;
	logic [7:0]                        shreg_q;
	logic [3:0]                        bits_q;
	logic                              stuff_q;
	logic [ax25_hdlc_pkg::FLAG_CW-1:0] flag_cnt_q;
	logic [2:0]                        flag_bit_q;
	logic [ax25_hdlc_pkg::RES_CW-1:0]  res_n_q, rd_ptr_q;
	logic                              rd_pend_q;
	logic                              trunc_q;
	logic                              out_valid_q, out_last_q, out_trunc_q;
	logic [7:0]                        out_byte_q;

	logic                              byte_phase, crc_en, lim_hit, step_end;
	logic [ax25_hdlc_pkg::ST_W-1:0]    nxt_state;
	logic [7:0]                        char_raw, char_val, hdr_byte, byte_now;
	logic                              hdr_pad, hdr_is_char;
	logic                              adv_en, adv_bit, force_emit, emit, emit_ok, fin_fill;
	logic [7:0]                        partial_or, emit_val;
	logic                              ram_wr, ram_rd;
	logic [7:0]                        ram_wdata, ram_rdata;
	logic                              res_room, push_bit;

	always_comb begin
		char_raw    = call_sh_q[ax25_hdlc_pkg::CALL_W-1 -: 8];
		hdr_pad     = pad_q | (char_raw == 8'd0);
		char_val    = hdr_pad ? ax25_hdlc_pkg::PAD_CHAR : char_raw;
		hdr_is_char = 1'b0;
		case (hdr_idx_q)
			ax25_hdlc_pkg::HDR_DEST_SSID: begin
				hdr_byte = {ax25_hdlc_pkg::DEST_SSID_TOP, dest_ssid_q, 1'b0};
			end
			ax25_hdlc_pkg::HDR_SRC_SSID: begin
				hdr_byte = {ax25_hdlc_pkg::SRC_SSID_TOP, src_ssid_q, 1'b1};
			end
			ax25_hdlc_pkg::HDR_CONTROL: begin
				hdr_byte = control_q;
			end
			ax25_hdlc_pkg::HDR_PID: begin
				hdr_byte = pid_q;
			end
			default: begin
				hdr_byte    = {char_val[6:0], 1'b0};
				hdr_is_char = 1'b1;
			end
		endcase

		case (state_q)
			ax25_hdlc_pkg::ST_HDR:  byte_now = ax25_hdlc_pkg::reverse8(hdr_byte);
			ax25_hdlc_pkg::ST_DATA: byte_now = ax25_hdlc_pkg::reverse8(data_q);
			ax25_hdlc_pkg::ST_CRCH: byte_now = ~crc_q[15:8];
			default:                byte_now = ~crc_q[7:0];
		endcase

		byte_phase = (state_q == ax25_hdlc_pkg::ST_HDR) || (state_q == ax25_hdlc_pkg::ST_DATA) ||
			(state_q == ax25_hdlc_pkg::ST_CRCH) || (state_q == ax25_hdlc_pkg::ST_CRCL);
		crc_en     = (state_q == ax25_hdlc_pkg::ST_HDR) || (state_q == ax25_hdlc_pkg::ST_DATA);
		lim_hit    = ({1'b0, out_cnt_q} + 13'd1) >= {1'b0, limit_q};
		step_end   = byte_phase && ((!byte_act_q && lim_hit) ||
			(byte_act_q && !stuff_q && (bits_q == ax25_hdlc_pkg::BYTE_BITS)));
		push_bit   = byte_phase && byte_act_q && !stuff_q && (bits_q != ax25_hdlc_pkg::BYTE_BITS);

		case (state_q)
			ax25_hdlc_pkg::ST_HDR: begin
				if (hdr_idx_q == ax25_hdlc_pkg::HDR_PID) begin
					nxt_state = item_valid_q ? ax25_hdlc_pkg::ST_DATA : ax25_hdlc_pkg::ST_CRCH;
				end else begin
					nxt_state = ax25_hdlc_pkg::ST_HDR;
				end
			end
			ax25_hdlc_pkg::ST_DATA: begin
				nxt_state = item_fend_q ? ax25_hdlc_pkg::ST_CRCH : ax25_hdlc_pkg::ST_FIN;
			end
			ax25_hdlc_pkg::ST_CRCH: nxt_state = ax25_hdlc_pkg::ST_CRCL;
			default:                nxt_state = ax25_hdlc_pkg::ST_FLAG;
		endcase

		adv_en     = 1'b0;
		adv_bit    = 1'b0;
		force_emit = 1'b0;
		fin_fill   = 1'b0;
		if (byte_phase && byte_act_q && stuff_q) begin
			adv_en = 1'b1;
		end else if (push_bit) begin
			adv_en  = 1'b1;
			adv_bit = shreg_q[7];
		end else if (state_q == ax25_hdlc_pkg::ST_FLAG) begin
			adv_en  = 1'b1;
			adv_bit = ax25_hdlc_pkg::FLAG_BYTE[flag_bit_q];
		end else if (state_q == ax25_hdlc_pkg::ST_PAD) begin
			force_emit = (bitpos_q != ax25_hdlc_pkg::BIT_TOP);
		end else if (state_q == ax25_hdlc_pkg::ST_FIN) begin
			fin_fill = item_fend_q && (res_n_q == '0);
		end

		partial_or = partial_q | (8'(adv_bit) << bitpos_q);
		emit       = force_emit || (adv_en && (bitpos_q == 3'd0));
		emit_val   = force_emit ? partial_q : partial_or;
		emit_ok    = out_cnt_q < limit_q;
		res_room   = res_n_q < ax25_hdlc_pkg::RES_CW'(ax25_hdlc_pkg::MAX_RESULTS);
		ram_wr     = (emit && emit_ok && res_room) || fin_fill;
		ram_wdata  = fin_fill ? 8'd0 : emit_val;
		ram_rd     = (state_q == ax25_hdlc_pkg::ST_DRAIN) && !rd_pend_q &&
			(rd_ptr_q != res_n_q) && (!out_valid_q || out_ready);
	end

	ax25_hdlc_ram #(
		.WIDTH(8),
		.DEPTH(ax25_hdlc_pkg::MAX_RESULTS)
	) u_res_ram (
		.clk    (clk),
		.wr_en  (ram_wr),
		.wr_addr(res_n_q[ax25_hdlc_pkg::RES_AW-1:0]),
		.wr_data(ram_wdata),
		.rd_en  (ram_rd),
		.rd_addr(rd_ptr_q[ax25_hdlc_pkg::RES_AW-1:0]),
		.rd_data(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dest_call_q  <= '0;
			src_call_q   <= '0;
			dest_ssid_q  <= '0;
			src_ssid_q   <= '0;
			control_q    <= ax25_hdlc_pkg::CONTROL_RESET;
			pid_q        <= ax25_hdlc_pkg::PID_RESET;
			limit_q      <= ax25_hdlc_pkg::LIMIT_RESET;
			state_q      <= ax25_hdlc_pkg::ST_IDLE;
			item_valid_q <= 1'b0;
			item_fend_q  <= 1'b0;
			data_q       <= '0;
			in_frame_q   <= 1'b0;
			crc_q        <= ax25_hdlc_pkg::CRC_INIT;
			ones_q       <= '0;
			bitpos_q     <= ax25_hdlc_pkg::BIT_TOP;
			partial_q    <= '0;
			out_cnt_q    <= '0;
			dropped_q    <= 1'b0;
			hdr_idx_q    <= '0;
			call_sh_q    <= '0;
			pad_q        <= 1'b0;
			byte_act_q   <= 1'b0;
			shreg_q      <= '0;
			bits_q       <= '0;
			stuff_q      <= 1'b0;
			flag_cnt_q   <= '0;
			flag_bit_q   <= '0;
			res_n_q      <= '0;
			rd_ptr_q     <= '0;
			rd_pend_q    <= 1'b0;
			trunc_q      <= 1'b0;
			out_valid_q  <= 1'b0;
			out_byte_q   <= '0;
			out_last_q   <= 1'b0;
			out_trunc_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					ax25_hdlc_pkg::CFG_DEST_CALL: dest_call_q <= cfg_wr_data;
					ax25_hdlc_pkg::CFG_DEST_SSID: dest_ssid_q <= cfg_wr_data[ax25_hdlc_pkg::SSID_W-1:0];
					ax25_hdlc_pkg::CFG_SRC_CALL:  src_call_q  <= cfg_wr_data;
					ax25_hdlc_pkg::CFG_SRC_SSID:  src_ssid_q  <= cfg_wr_data[ax25_hdlc_pkg::SSID_W-1:0];
					ax25_hdlc_pkg::CFG_CONTROL:   control_q   <= cfg_wr_data[7:0];
					ax25_hdlc_pkg::CFG_PID:       pid_q       <= cfg_wr_data[7:0];
					ax25_hdlc_pkg::CFG_LIMIT:     limit_q     <= cfg_wr_data[ax25_hdlc_pkg::LIMIT_W-1:0];
					default: begin
					end
				endcase
			end

			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (adv_en) begin
				if (bitpos_q == 3'd0) begin
					partial_q <= '0;
					bitpos_q  <= ax25_hdlc_pkg::BIT_TOP;
				end else begin
					partial_q <= partial_or;
					bitpos_q  <= bitpos_q - 3'd1;
				end
			end
			if (force_emit) begin
				partial_q <= '0;
				bitpos_q  <= ax25_hdlc_pkg::BIT_TOP;
			end
			if (emit) begin
				if (emit_ok) begin
					out_cnt_q <= out_cnt_q + 1'b1;
				end else begin
					dropped_q <= 1'b1;
				end
			end
			if (ram_wr) begin
				res_n_q <= res_n_q + 1'b1;
			end

			case (state_q)
				ax25_hdlc_pkg::ST_IDLE: begin
					if (in_valid && (byte_valid || frame_end)) begin
						item_valid_q <= byte_valid;
						item_fend_q  <= frame_end;
						data_q       <= data_byte;
						res_n_q      <= '0;
						byte_act_q   <= 1'b0;
						if (!in_frame_q) begin
							in_frame_q <= 1'b1;
							hdr_idx_q  <= '0;
							call_sh_q  <= dest_call_q;
							pad_q      <= 1'b0;
							state_q    <= ax25_hdlc_pkg::ST_HDR;
						end else if (byte_valid) begin
							state_q <= ax25_hdlc_pkg::ST_DATA;
						end else begin
							state_q <= ax25_hdlc_pkg::ST_CRCH;
						end
					end
				end
				ax25_hdlc_pkg::ST_HDR, ax25_hdlc_pkg::ST_DATA,
				ax25_hdlc_pkg::ST_CRCH, ax25_hdlc_pkg::ST_CRCL: begin
					if (!byte_act_q) begin
						if ((state_q == ax25_hdlc_pkg::ST_HDR) && hdr_is_char) begin
							pad_q     <= hdr_pad;
							call_sh_q <= {call_sh_q[ax25_hdlc_pkg::CALL_W-9:0], 8'd0};
						end
						if (lim_hit) begin
							dropped_q <= 1'b1;
						end else begin
							byte_act_q <= 1'b1;
							shreg_q    <= byte_now;
							bits_q     <= '0;
						end
					end else if (stuff_q) begin
						stuff_q <= 1'b0;
						ones_q  <= '0;
					end else if (bits_q == ax25_hdlc_pkg::BYTE_BITS) begin
						byte_act_q <= 1'b0;
					end else begin
						shreg_q <= {shreg_q[6:0], 1'b0};
						bits_q  <= bits_q + 4'd1;
						if (shreg_q[7]) begin
							ones_q <= ones_q + 3'd1;
							if (ones_q + 3'd1 == ax25_hdlc_pkg::STUFF_RUN) begin
								stuff_q <= 1'b1;
							end
						end else begin
							ones_q <= '0;
						end
						if (crc_en) begin
							crc_q <= {crc_q[14:0], 1'b0} ^
								((crc_q[15] ^ shreg_q[7]) ? ax25_hdlc_pkg::CRC_POLY : 16'd0);
						end
					end
					if (step_end) begin
						state_q <= nxt_state;
						if (state_q == ax25_hdlc_pkg::ST_HDR) begin
							hdr_idx_q <= hdr_idx_q + 4'd1;
							if (hdr_idx_q == ax25_hdlc_pkg::HDR_DEST_SSID) begin
								call_sh_q <= src_call_q;
								pad_q     <= 1'b0;
							end
						end
					end
				end
				ax25_hdlc_pkg::ST_FLAG: begin
					flag_bit_q <= flag_bit_q + 3'd1;
					if (flag_bit_q == ax25_hdlc_pkg::BIT_TOP) begin
						if (flag_cnt_q ==
							ax25_hdlc_pkg::FLAG_CW'(ax25_hdlc_pkg::END_FLAGS - 1)) begin
							flag_cnt_q <= '0;
							state_q    <= ax25_hdlc_pkg::ST_PAD;
						end else begin
							flag_cnt_q <= flag_cnt_q + 1'b1;
						end
					end
				end
				ax25_hdlc_pkg::ST_PAD: begin
					state_q <= ax25_hdlc_pkg::ST_FIN;
				end
				ax25_hdlc_pkg::ST_FIN: begin
					trunc_q   <= dropped_q;
					rd_ptr_q  <= '0;
					rd_pend_q <= 1'b0;
					state_q   <= ax25_hdlc_pkg::ST_DRAIN;
					if (item_fend_q) begin
						in_frame_q <= 1'b0;
						crc_q      <= ax25_hdlc_pkg::CRC_INIT;
						ones_q     <= '0;
						stuff_q    <= 1'b0;
						bitpos_q   <= ax25_hdlc_pkg::BIT_TOP;
						partial_q  <= '0;
						out_cnt_q  <= '0;
						dropped_q  <= 1'b0;
					end
				end
				ax25_hdlc_pkg::ST_DRAIN: begin
					if (rd_pend_q) begin
						rd_pend_q   <= 1'b0;
						out_valid_q <= 1'b1;
						out_byte_q  <= ram_rdata;
						out_last_q  <= item_fend_q && (rd_ptr_q == res_n_q);
						out_trunc_q <= trunc_q;
						if (rd_ptr_q == res_n_q) begin
							state_q <= ax25_hdlc_pkg::ST_IDLE;
						end
					end else if (rd_ptr_q == res_n_q) begin
						state_q <= ax25_hdlc_pkg::ST_IDLE;
					end else if (ram_rd) begin
						rd_ptr_q  <= rd_ptr_q + 1'b1;
						rd_pend_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ax25_hdlc_pkg::ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = (state_q == ax25_hdlc_pkg::ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;
	assign truncated = out_trunc_q;

endmodule

>>> rtl/ax25_hdlc_chk.sv
// ----------------------------------------------------------------------------
// AX.25 HDLC encoder checker
// Port-level properties of the encoder, attached to the top level by bind.
// ----------------------------------------------------------------------------
module ax25_hdlc_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       byte_valid,
	input logic       frame_end,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       out_last,
	input logic       truncated
);

	// A stalled result keeps its payload until the transfer.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
		$stable(out_last) && $stable(truncated))
		else $error("result changed while stalled");

	// An item carrying neither a byte nor a close leaves the block idle.
	a_idle_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !byte_valid && !frame_end |=> in_ready)
		else $error("empty item started work");

	// A real item keeps the input closed in the next cycle.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (byte_valid || frame_end) |=> !in_ready)
		else $error("input open right after a real item");

	// Results appear only while the block is working on an item.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared while idle");

endmodule

bind ax25_hdlc_frame_encoder_unit ax25_hdlc_chk u_ax25_hdlc_chk (.*);
